FILE: sv/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int LIMIT_W = 11;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [ADDR_W-1:0]  REG_RECOVERY_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET        = 11'd1000;
  localparam logic [3:0]         BITS_PER_BYTE      = 4'd8;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rbyte;
    logic       absent;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Open-drain I2C master, one bus delay tick per request.
// Request channel (req_valid / req_stall) carries command, data_byte, send_ack
// and the SDA level sampled at the end of the tick. Start, stop, write byte and
// read byte are taken only while idle; other commands are ignored.
// Every request yields exactly one result on the result channel
// (res_valid / res_stall): line drives for the tick, busy/done status, the
// last write ACK, the last read byte and the sticky device-absent flag.
// The result is registered; the engine takes one request per cycle while req_stall
// is low, and all work for a tick is done in a single pass of logic between the
// state registers and the result register.
// When the receiver stalls, one more result is parked in a skid register and
// req_stall rises until the parked result has moved forward.
// Reset (rst, synchronous) returns the engine to idle with both lines
// released, clears the flags and sets recovery_limit to 1000. The register
// is written over the APB port at byte address 0 and should only be changed
// while no operation is running.
module i2c_master_byte_engine (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [i2cm_pkg::ADDR_W-1:0]   paddr,
  input  wire [i2cm_pkg::DATA_W-1:0]   pwdata,
  output logic [i2cm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  wire                          req_valid,
  output logic                         req_stall,
  input  wire [2:0]                    command,
  input  wire [7:0]                    data_byte,
  input  wire                          send_ack,
  input  wire                          sda_line,
  output logic                         res_valid,
  input  wire                          res_stall,
  output logic                         scl_out,
  output logic                         sda_out,
  output logic                         busy_res,
  output logic                         done_res,
  output logic                         ack_received,
  output logic [7:0]                   read_byte,
  output logic                         device_absent
);

  logic [i2cm_pkg::LIMIT_W-1:0] recovery_limit;

  i2cm_pkg::op_t                operation, operation_next;
  logic [2:0]                   phase, phase_next;
  logic [3:0]                   bit_count, bit_count_next;
  logic [7:0]                   shift_reg, shift_reg_next;
  logic [i2cm_pkg::LIMIT_W-1:0] recovery_count, recovery_count_next;
  logic                         absent_flag, absent_flag_next;
  logic                         scl_drive, scl_drive_next;
  logic                         sda_drive, sda_drive_next;
  logic                         ack_flag, ack_flag_next;
  logic [7:0]                   read_hold, read_hold_next;
  logic                         ack_choice, ack_choice_next;
  logic                         finish;
  logic                         scl_tick, sda_tick;

  i2cm_pkg::res_t res_new, res_q, skid;
  logic           skid_valid;
  logic           req_take, res_take;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == i2cm_pkg::REG_RECOVERY_LIMIT) ?
                  i2cm_pkg::DATA_W'(recovery_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_limit <= i2cm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == i2cm_pkg::REG_RECOVERY_LIMIT) begin
      recovery_limit <= pwdata[i2cm_pkg::LIMIT_W-1:0];
    end
  end

  assign req_take  = req_valid && !req_stall;
  assign res_take  = res_valid && !res_stall;
  assign req_stall = skid_valid;

  // one tick of the engine: command load, then the action after the delay
  always_comb begin
    operation_next      = operation;
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    recovery_count_next = recovery_count;
    absent_flag_next    = absent_flag;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    ack_flag_next       = ack_flag;
    read_hold_next      = read_hold;
    ack_choice_next     = ack_choice;
    finish              = 1'b0;

    if (operation == i2cm_pkg::OP_IDLE) begin
      case (command)
        i2cm_pkg::OP_START: begin
          operation_next      = i2cm_pkg::OP_START;
          phase_next          = '0;
          bit_count_next      = '0;
          sda_drive_next      = 1'b1;
          recovery_count_next = '0;
        end
        i2cm_pkg::OP_STOP: begin
          operation_next = i2cm_pkg::OP_STOP;
          phase_next     = '0;
          bit_count_next = '0;
          sda_drive_next = 1'b0;
        end
        i2cm_pkg::OP_WRITE: begin
          operation_next = i2cm_pkg::OP_WRITE;
          phase_next     = '0;
          bit_count_next = '0;
          shift_reg_next = data_byte;
          sda_drive_next = data_byte[7];
        end
        i2cm_pkg::OP_READ: begin
          operation_next  = i2cm_pkg::OP_READ;
          phase_next      = '0;
          bit_count_next  = '0;
          sda_drive_next  = 1'b1;
          shift_reg_next  = '0;
          ack_choice_next = send_ack;
        end
        default: begin
        end
      endcase
    end

    scl_tick = scl_drive_next;
    sda_tick = sda_drive_next;

    case (operation_next)
      i2cm_pkg::OP_START: begin
        case (phase_next)
          3'd0: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd1;
          end
          3'd1: begin
            if (sda_line) begin
              sda_drive_next = 1'b0;
              phase_next     = 3'd3;
            end else if (recovery_count_next >= recovery_limit) begin
              absent_flag_next = 1'b1;
              finish           = 1'b1;
            end else begin
              recovery_count_next = recovery_count_next + 1'b1;
              scl_drive_next      = 1'b0;
              phase_next          = 3'd2;
            end
          end
          3'd2: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd1;
          end
          3'd3: begin
            scl_drive_next = 1'b0;
            phase_next     = 3'd4;
          end
          default: finish = 1'b1;
        endcase
      end
      i2cm_pkg::OP_STOP: begin
        case (phase_next)
          3'd0: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd1;
          end
          3'd1: begin
            sda_drive_next = 1'b1;
            phase_next     = 3'd2;
          end
          default: finish = 1'b1;
        endcase
      end
      i2cm_pkg::OP_WRITE: begin
        case (phase_next)
          3'd0: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd1;
          end
          3'd1: begin
            scl_drive_next = 1'b0;
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
            bit_count_next = bit_count_next + 1'b1;
            if (bit_count_next < i2cm_pkg::BITS_PER_BYTE) begin
              sda_drive_next = shift_reg_next[7];
              phase_next     = 3'd0;
            end else begin
              sda_drive_next = 1'b1;
              phase_next     = 3'd2;
            end
          end
          3'd2: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd3;
          end
          default: begin
            ack_flag_next  = !sda_line;
            scl_drive_next = 1'b0;
            sda_drive_next = 1'b0;
            finish         = 1'b1;
          end
        endcase
      end
      i2cm_pkg::OP_READ: begin
        case (phase_next)
          3'd0: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd1;
          end
          3'd1: begin
            shift_reg_next = {shift_reg_next[6:0], sda_line};
            scl_drive_next = 1'b0;
            bit_count_next = bit_count_next + 1'b1;
            if (bit_count_next < i2cm_pkg::BITS_PER_BYTE) begin
              phase_next = 3'd0;
            end else begin
              if (ack_choice_next) begin
                sda_drive_next = 1'b0;
              end
              phase_next = 3'd2;
            end
          end
          3'd2: begin
            scl_drive_next = 1'b1;
            phase_next     = 3'd3;
          end
          default: begin
            scl_drive_next = 1'b0;
            sda_drive_next = 1'b1;
            read_hold_next = shift_reg_next;
            finish         = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    res_new.scl    = scl_tick;
    res_new.sda    = sda_tick;
    res_new.busy   = (operation_next != i2cm_pkg::OP_IDLE) && !finish;
    res_new.done   = finish;
    res_new.ack    = ack_flag_next;
    res_new.rbyte  = read_hold_next;
    res_new.absent = absent_flag_next;

    if (finish) begin
      operation_next = i2cm_pkg::OP_IDLE;
      phase_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation      <= i2cm_pkg::OP_IDLE;
      phase          <= '0;
      bit_count      <= '0;
      shift_reg      <= '0;
      recovery_count <= '0;
      absent_flag    <= 1'b0;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
      ack_flag       <= 1'b0;
      read_hold      <= '0;
      ack_choice     <= 1'b0;
    end else if (req_take) begin
      operation      <= operation_next;
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      recovery_count <= recovery_count_next;
      absent_flag    <= absent_flag_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
      ack_flag       <= ack_flag_next;
      read_hold      <= read_hold_next;
      ack_choice     <= ack_choice_next;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_take || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= req_take;
      end
    end else if (req_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take || !res_valid) begin
      if (skid_valid) begin
        res_q <= skid;
      end else if (req_take) begin
        res_q <= res_new;
      end
    end else if (req_take) begin
      skid <= res_new;
    end
  end

  assign scl_out       = res_q.scl;
  assign sda_out       = res_q.sda;
  assign busy_res      = res_q.busy;
  assign done_res      = res_q.done;
  assign ack_received  = res_q.ack;
  assign read_byte     = res_q.rbyte;
  assign device_absent = res_q.absent;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without a result in the output register");

  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(busy_res && done_res))
    else $error("result shows busy and done together");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (operation == i2cm_pkg::OP_IDLE) |-> (phase == 3'd0))
    else $error("idle engine with nonzero phase");

  a_absent_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $past(res_valid && device_absent) && res_valid) |-> device_absent)
    else $error("device absent flag dropped without reset");

  a_stall_no_take: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && req_valid) |=> $stable(operation) && $stable(phase))
    else $error("engine state moved while requests were stalled");

endmodule

`default_nettype wire
